FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent property checks, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define RPFA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");
// expression must never be true outside reset
`define RPFA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define RPFA_ASSERT(lbl, clk, rst_n, prop)
`define RPFA_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: design/rpfa_pkg.sv
// ----------------------------------------------------------------------------
// rpfa_pkg
// shared constants, codes and types of the page frame allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpfa_pkg;

  // page table size and derived memory geometry
  localparam int NUM_PAGES = 65536;
  localparam int MEM_DEPTH = (NUM_PAGES < 65536) ? NUM_PAGES : 65536;
  localparam int IDX_W     = $clog2(MEM_DEPTH);

  // field widths
  localparam int PAGE_W  = 16;
  localparam int COUNT_W = 16;
  localparam int LINK_W  = 17;

  // end of list marker and count ceiling
  localparam logic [LINK_W-1:0]  END_MARK  = {1'b1, {(LINK_W-1){1'b0}}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_ADDREF = 2'd2,
    CMD_GETREF = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  // one result item
  typedef struct packed {
    logic [PAGE_W-1:0]  result_page;
    logic [COUNT_W-1:0] count;
    logic               released;
    status_e            status;
  } res_t;

  // operands of one command, read data included
  typedef struct packed {
    cmd_e               cmd;
    logic [PAGE_W-1:0]  page;
    logic [PAGE_W-1:0]  lowest;
    logic [LINK_W-1:0]  head;
    logic [COUNT_W-1:0] cnt_rd;
    logic [LINK_W-1:0]  link_rd;
  } eval_req_t;

  // result and write-back controls of one command
  typedef struct packed {
    res_t               res;
    logic               cnt_we;
    logic [IDX_W-1:0]   cnt_addr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic               link_we;
    logic [LINK_W-1:0]  link_wdata;
    logic               head_we;
    logic [LINK_W-1:0]  head_nxt;
  } eval_rsp_t;

endpackage

`default_nettype wire

FILE: design/rpfa_cmd_if.sv
// ----------------------------------------------------------------------------
// rpfa_cmd_if
// command channel: valid, ready, command code and page index
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rpfa_cmd_if;
  import rpfa_pkg::*;

  logic              valid;
  logic              ready;
  cmd_e              command;
  logic [PAGE_W-1:0] page;

  modport source (output valid, output command, output page, input ready);
  modport sink   (input valid, input command, input page, output ready);
endinterface

`default_nettype wire

FILE: design/rpfa_res_if.sv
// ----------------------------------------------------------------------------
// rpfa_res_if
// result channel: valid, ready and the four result fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rpfa_res_if;
  import rpfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [PAGE_W-1:0]  result_page;
  logic [COUNT_W-1:0] count;
  logic               released;
  status_e            status;

  modport source (output valid, output result_page, output count, output released,
                  output status, input ready);
  modport sink   (input valid, input result_page, input count, input released,
                  input status, output ready);
endinterface

`default_nettype wire

FILE: design/rpfa_cfg_if.sv
// ----------------------------------------------------------------------------
// rpfa_cfg_if
// configuration write channel for the lowest page register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rpfa_cfg_if;
  import rpfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/rpfa_ram.sv
// ----------------------------------------------------------------------------
// rpfa_ram
// single port synchronous ram, registered read data held between reads
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpfa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/rpfa_eval.sv
// ----------------------------------------------------------------------------
// rpfa_eval
// command evaluation: result fields and write-back of count, link and head
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpfa_eval (
  input  rpfa_pkg::eval_req_t req_i,
  output rpfa_pkg::eval_rsp_t rsp_o
);
  import rpfa_pkg::*;

  logic               in_range;
  logic               below_low;
  logic               push;
  logic [COUNT_W-1:0] c;
  logic [COUNT_W-1:0] c_dec;

  // range checks on the page operand
  assign in_range  = ({{(32-PAGE_W){1'b0}}, req_i.page} < 32'(NUM_PAGES));
  assign below_low = (req_i.page < req_i.lowest);

  assign c     = req_i.cnt_rd;
  assign c_dec = (c == '0) ? '0 : c - COUNT_W'(1);
  assign push  = (c == '0) || (c == COUNT_W'(1));

  // per command outcome
  always_comb begin
    rsp_o            = '0;
    rsp_o.res.status = ST_OK;
    unique case (req_i.cmd)
      CMD_ALLOC: begin
        if (req_i.head[LINK_W-1]) begin
          rsp_o.res.status = ST_EMPTY;
        end else begin
          rsp_o.res.result_page = req_i.head[PAGE_W-1:0];
          rsp_o.res.count       = COUNT_W'(1);
          rsp_o.cnt_we          = 1'b1;
          rsp_o.cnt_addr        = req_i.head[IDX_W-1:0];
          rsp_o.cnt_wdata       = COUNT_W'(1);
          rsp_o.head_we         = 1'b1;
          rsp_o.head_nxt        = req_i.link_rd;
        end
      end
      CMD_FREE: begin
        if (!in_range || below_low) begin
          rsp_o.res.status = ST_RANGE;
        end else begin
          rsp_o.res.count    = c_dec;
          rsp_o.res.released = push;
          rsp_o.cnt_we       = (c != '0);
          rsp_o.cnt_addr     = req_i.page[IDX_W-1:0];
          rsp_o.cnt_wdata    = c_dec;
          rsp_o.link_we      = push;
          rsp_o.link_wdata   = req_i.head;
          rsp_o.head_we      = push;
          rsp_o.head_nxt     = {1'b0, req_i.page};
        end
      end
      CMD_ADDREF: begin
        if (!in_range) begin
          rsp_o.res.status = ST_RANGE;
        end else if (c == COUNT_MAX) begin
          rsp_o.res.status = ST_SAT;
          rsp_o.res.count  = COUNT_MAX;
        end else begin
          rsp_o.res.count = c + COUNT_W'(1);
          rsp_o.cnt_we    = 1'b1;
          rsp_o.cnt_addr  = req_i.page[IDX_W-1:0];
          rsp_o.cnt_wdata = c + COUNT_W'(1);
        end
      end
      CMD_GETREF: begin
        if (!in_range) begin
          rsp_o.res.status = ST_RANGE;
        end else begin
          rsp_o.res.count = c;
        end
      end
      default: begin
        rsp_o.res.status = ST_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/refcounted_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator
// lifo free list page allocator with per-page reference counts
// ----------------------------------------------------------------------------
//
// channel   dir   transaction
// cmd_i     in    command code and page index
// res_o     out   result page, count, released flag, status
// cfg_i     in    lowest page register write
//
// each command takes two steps: one to read the count and link rams,
// one to evaluate and write back; the single port of each ram sets this.
// after reset the count ram is cleared, one entry a cycle, over all MEM_DEPTH
// (65536) entries; no command is taken then, configuration writes are.
// a held result stalls the write-back cycle until res_o is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module refcounted_page_frame_allocator (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  rpfa_cmd_if.sink   cmd_i,
  rpfa_res_if.source res_o,
  rpfa_cfg_if.sink   cfg_i
);
  import rpfa_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e             state_q;
  logic [IDX_W-1:0]   clr_q;
  logic [LINK_W-1:0]  head_q;
  logic [PAGE_W-1:0]  lowest_q;
  logic               out_valid_q;
  cmd_e               cmd_q;
  logic [PAGE_W-1:0]  page_q;
  res_t               res_q;

  logic               cmd_acc;
  logic               exec_fire;

  logic               cnt_en;
  logic               cnt_we;
  logic [IDX_W-1:0]   cnt_addr;
  logic [COUNT_W-1:0] cnt_wdata;
  logic [COUNT_W-1:0] cnt_rdata;
  logic               link_en;
  logic               link_we;
  logic [IDX_W-1:0]   link_addr;
  logic [LINK_W-1:0]  link_wdata;
  logic [LINK_W-1:0]  link_rdata;

  eval_req_t          req;
  eval_rsp_t          rsp;

  // handshakes
  assign cmd_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign exec_fire   = (state_q == S_EXEC) && (!out_valid_q || res_o.ready);

  // ram port control
  always_comb begin
    cnt_en     = 1'b0;
    cnt_we     = 1'b0;
    cnt_addr   = cmd_i.page[IDX_W-1:0];
    cnt_wdata  = '0;
    link_en    = 1'b0;
    link_we    = 1'b0;
    link_addr  = head_q[IDX_W-1:0];
    link_wdata = rsp.link_wdata;
    unique case (state_q)
      S_CLEAR: begin
        cnt_en   = 1'b1;
        cnt_we   = 1'b1;
        cnt_addr = clr_q;
      end
      S_IDLE: begin
        cnt_en  = cmd_acc;
        link_en = cmd_acc;
      end
      S_EXEC: begin
        cnt_en    = exec_fire && rsp.cnt_we;
        cnt_we    = 1'b1;
        cnt_addr  = rsp.cnt_addr;
        cnt_wdata = rsp.cnt_wdata;
        link_en   = exec_fire && rsp.link_we;
        link_we   = 1'b1;
        link_addr = page_q[IDX_W-1:0];
      end
      default: begin
        cnt_en = 1'b0;
      end
    endcase
  end

  // reference count store
  rpfa_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (COUNT_W)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .en_i    (cnt_en),
    .we_i    (cnt_we),
    .addr_i  (cnt_addr),
    .wdata_i (cnt_wdata),
    .rdata_o (cnt_rdata)
  );

  // free list link store
  rpfa_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (LINK_W)
  ) u_link_ram (
    .clk_i   (clk_i),
    .en_i    (link_en),
    .we_i    (link_we),
    .addr_i  (link_addr),
    .wdata_i (link_wdata),
    .rdata_o (link_rdata)
  );

  // command evaluation on the read data
  assign req = '{cmd: cmd_q, page: page_q, lowest: lowest_q, head: head_q,
                 cnt_rd: cnt_rdata, link_rd: link_rdata};

  rpfa_eval u_eval (
    .req_i (req),
    .rsp_o (rsp)
  );

  // lowest page register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      lowest_q <= cfg_i.data;
    end
  end

  // sequencer, free list head and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      head_q      <= END_MARK;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + IDX_W'(1);
          if (clr_q == IDX_W'(MEM_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_acc) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            state_q <= S_IDLE;
            if (rsp.head_we) begin
              head_q <= rsp.head_nxt;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      cmd_q  <= cmd_i.command;
      page_q <= cmd_i.page;
    end
    if (exec_fire) begin
      res_q <= rsp.res;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.result_page = res_q.result_page;
  assign res_o.count       = res_q.count;
  assign res_o.released    = res_q.released;
  assign res_o.status      = res_q.status;

  // checks
  `RPFA_ASSERT(a_accept_exec, clk_i, rst_ni, cmd_acc |=> (state_q == S_EXEC))
  `RPFA_ASSERT(a_one_result, clk_i, rst_ni, exec_fire |=> (state_q != S_EXEC))
  `RPFA_ASSERT(a_alloc_count, clk_i, rst_ni, (res_o.valid && (res_o.result_page != '0)) |-> (res_o.count == COUNT_W'(1)))
  `RPFA_ASSERT_NEVER(a_release_ok, clk_i, rst_ni, res_o.valid && res_o.released && ((res_o.count != '0) || (res_o.status != ST_OK)))

endmodule

`default_nettype wire

FILE: tb/refcounted_page_frame_allocator_tb.sv
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_tb
// self-checking bench for the reference counted page frame allocator: a
// queue-fed command driver, a result monitor and an in-bench predictor of the
// free list, link store and count store, run through several lowest page
// settings with directed, repeated reference and random command streams
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module refcounted_page_frame_allocator_tb;
  import rpfa_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int REF_REPEAT     = 20;

  typedef struct {
    cmd_e              cmd;
    logic [PAGE_W-1:0] page;
  } page_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rpfa_cmd_if cmd_if ();
  rpfa_res_if res_if ();
  rpfa_cfg_if cfg_if ();

  refcounted_page_frame_allocator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predicted allocator state
  logic [LINK_W-1:0]  free_top;
  logic [LINK_W-1:0]  below_link [0:NUM_PAGES-1];
  logic [COUNT_W-1:0] page_refs  [0:NUM_PAGES-1];
  logic [PAGE_W-1:0]  lowest_pg;

  page_cmd_t cmd_backlog_q[$];
  res_t      owed_res_q[$];

  // bench controls and bookkeeping
  bit   idle_on;
  bit   press_arm;
  bit   press_done;
  int   hold_cnt;
  int   send_gap;
  int   recv_gap;
  int   quiet_cycles;
  int   n_err;
  int   n_cmd;
  int   n_res;
  int   n_cfg;
  int   n_released;
  int   n_status [4];
  page_cmd_t next_cmd;
  res_t      mon_want;

  // apply one command to the predicted state, return its result
  function automatic res_t apply_command(cmd_e c, logic [PAGE_W-1:0] pg);
    res_t               r;
    logic [COUNT_W-1:0] cur;
    logic               push;
    r        = '0;
    r.status = ST_OK;
    if (c == CMD_ALLOC) begin
      if (free_top >= END_MARK || free_top >= NUM_PAGES) begin
        r.status = ST_EMPTY;
      end else begin
        r.result_page = free_top[PAGE_W-1:0];
        r.count       = 1;
        page_refs[free_top[PAGE_W-1:0]] = 1;
        free_top = below_link[free_top[PAGE_W-1:0]];
      end
      return r;
    end
    if (int'(pg) >= NUM_PAGES || (c == CMD_FREE && pg < lowest_pg)) begin
      r.status = ST_RANGE;
      return r;
    end
    cur = page_refs[pg];
    case (c)
      CMD_FREE: begin
        push = 1'b0;
        if (cur == 0) begin
          push = 1'b1;
        end else begin
          cur = cur - 1;
          page_refs[pg] = cur;
          push = (cur == 0);
        end
        if (push) begin
          below_link[pg] = free_top;
          free_top = {1'b0, pg};
        end
        r.count    = cur;
        r.released = push;
      end
      CMD_ADDREF: begin
        if (cur == COUNT_MAX) begin
          r.count  = COUNT_MAX;
          r.status = ST_SAT;
        end else begin
          page_refs[pg] = cur + 1;
          r.count = cur + 1;
        end
      end
      default: begin
        r.count = cur;
      end
    endcase
    return r;
  endfunction

  // command driver, fed from the backlog queue
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) begin
        owed_res_q.push_back(apply_command(cmd_if.command, cmd_if.page));
        n_cmd++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          cmd_if.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 16);
          cmd_if.valid <= 1'b0;
        end else if (cmd_backlog_q.size() != 0) begin
          next_cmd = cmd_backlog_q.pop_front();
          cmd_if.valid   <= 1'b1;
          cmd_if.command <= next_cmd.cmd;
          cmd_if.page    <= next_cmd.page;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, so the block fills up and backpressures commands
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (press_arm && !press_done) begin
      hold_cnt   <= HOLD_CYCLES;
      press_done <= 1'b1;
    end
  end

  // result monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        n_res++;
        if (owed_res_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result, actual page %0d count %0d released %0b status %0d",
                   $time, res_if.result_page, res_if.count, res_if.released, res_if.status);
        end else begin
          mon_want = owed_res_q.pop_front();
          n_status[mon_want.status]++;
          if (mon_want.released) n_released++;
          if (res_if.result_page !== mon_want.result_page || res_if.count !== mon_want.count ||
              res_if.released !== mon_want.released || res_if.status !== mon_want.status) begin
            n_err++;
            if (n_err <= 40) begin
              $display("%0t: mismatch, expected page %0d count %0d released %0b status %0d,",
                       $time, mon_want.result_page, mon_want.count, mon_want.released,
                       mon_want.status);
              $display("%0t:   actual page %0d count %0d released %0b status %0d",
                       $time, res_if.result_page, res_if.count, res_if.released,
                       res_if.status);
            end
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 16);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= (hold_cnt == 0);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_cmd(input cmd_e c, input logic [PAGE_W-1:0] pg);
    page_cmd_t it;
    it.cmd  = c;
    it.page = pg;
    cmd_backlog_q.push_back(it);
  endtask

  // lowest page register write, with no commands in flight
  task automatic write_lowest(input logic [PAGE_W-1:0] v);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    lowest_pg = v;
    n_cfg++;
    @(negedge clk_i);
  endtask

  // wait until every command is sent and every result is back
  task automatic wait_drained();
    @(negedge clk_i);
    while (cmd_backlog_q.size() != 0 || cmd_if.valid || owed_res_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // random mix, mostly pages from a small pool at the lowest page
  task automatic queue_random(input int n);
    page_cmd_t it;
    int        base;
    int        sel;
    base = (lowest_pg > 16'hFFDF) ? 16'hFFE0 : int'(lowest_pg);
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      it.cmd = (sel < 30) ? CMD_ALLOC : (sel < 65) ? CMD_FREE :
               (sel < 85) ? CMD_ADDREF : CMD_GETREF;
      sel = $urandom_range(0, 99);
      if (sel < 20)
        it.page = PAGE_W'($urandom);
      else if (sel < 30 && lowest_pg != 0)
        it.page = PAGE_W'($urandom_range(0, int'(lowest_pg) - 1));
      else
        it.page = PAGE_W'(base + $urandom_range(0, 31));
      cmd_backlog_q.push_back(it);
    end
  endtask

  initial begin
    logic [PAGE_W-1:0] mid_low;
    rst_ni         = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.command = CMD_ALLOC;
    cmd_if.page    = '0;
    res_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    free_top       = END_MARK;
    lowest_pg      = '0;
    idle_on        = 1'b1;
    for (int i = 0; i < NUM_PAGES; i++) begin
      page_refs[i]  = '0;
      below_link[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // written while the count store is still being cleared
    write_lowest(16'd16);

    // directed: empty list, range errors, duplicate push, counting up and down
    queue_cmd(CMD_ALLOC, 16'h0000);
    queue_cmd(CMD_FREE, 16'd15);
    queue_cmd(CMD_GETREF, 16'hFFFF);
    queue_cmd(CMD_FREE, 16'd16);
    queue_cmd(CMD_FREE, 16'hFFFF);
    queue_cmd(CMD_FREE, 16'd16);
    queue_cmd(CMD_ALLOC, 16'hFFFF);
    queue_cmd(CMD_ALLOC, 16'h0000);
    queue_cmd(CMD_ADDREF, 16'd16);
    queue_cmd(CMD_FREE, 16'd16);
    queue_cmd(CMD_GETREF, 16'd16);
    queue_cmd(CMD_FREE, 16'd16);
    queue_cmd(CMD_ALLOC, 16'h5555);
    queue_cmd(CMD_ALLOC, 16'hAAAA);
    queue_cmd(CMD_ALLOC, 16'h0000);
    queue_cmd(CMD_ADDREF, 16'h0000);
    queue_cmd(CMD_GETREF, 16'h0000);
    queue_cmd(CMD_FREE, 16'h0000);
    queue_cmd(CMD_ADDREF, 16'h8000);
    queue_cmd(CMD_GETREF, 16'h5555);
    queue_cmd(CMD_FREE, 16'hAAAA);
    wait_drained();

    // top setting: only the last page may be freed
    write_lowest(16'hFFFF);
    queue_cmd(CMD_FREE, 16'hFFFE);
    queue_cmd(CMD_FREE, 16'h0000);
    queue_cmd(CMD_FREE, 16'hFFFF);
    queue_cmd(CMD_ALLOC, 16'h0000);
    queue_cmd(CMD_ALLOC, 16'h0000);
    wait_drained();

    // repeated references on one page, no idling
    write_lowest(16'h0000);
    idle_on = 1'b0;
    queue_cmd(CMD_FREE, 16'h0000);
    for (int k = 0; k < REF_REPEAT; k++) queue_cmd(CMD_ADDREF, 16'h1234);
    queue_cmd(CMD_GETREF, 16'h1234);
    queue_cmd(CMD_FREE, 16'h1234);
    queue_cmd(CMD_ADDREF, 16'h1234);
    wait_drained();

    // random phases across several lowest page settings
    idle_on = 1'b1;
    write_lowest(16'h0040);
    press_arm = 1'b1;
    queue_random(400);
    wait_drained();

    mid_low = PAGE_W'($urandom_range(1, 65534));
    write_lowest(mid_low);
    queue_random(350);
    wait_drained();

    write_lowest(16'hFFFF);
    queue_random(150);
    wait_drained();

    // last part without idling
    idle_on = 1'b0;
    write_lowest(16'h0000);
    queue_random(420);
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (owed_res_q.size() != 0) begin
      n_err++;
      $display("%0t: %0d results never arrived", $time, owed_res_q.size());
    end
    $display("run covered %0d commands and %0d results over %0d lowest page writes",
             n_cmd, n_res, n_cfg);
    $display("  ok %0d, list empty %0d, out of range %0d, saturated %0d, pages released %0d",
             n_status[ST_OK], n_status[ST_EMPTY], n_status[ST_RANGE], n_status[ST_SAT],
             n_released);
    if (n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: refcounted_page_frame_allocator.f
+incdir+design
design/rpfa_pkg.sv
design/rpfa_cmd_if.sv
design/rpfa_res_if.sv
design/rpfa_cfg_if.sv
design/rpfa_ram.sv
design/rpfa_eval.sv
design/refcounted_page_frame_allocator.sv
tb/refcounted_page_frame_allocator_tb.sv
